// ===== rtl/mpfb_pkg.sv =====
// mpfb_pkg: command codes, control/status types, font and glyph tables
// for the page-organized monochrome framebuffer engine
// no dependencies
package mpfb_pkg;

    // input command codes
    localparam logic [2:0] CMD_SET_PIXEL   = 3'd0;
    localparam logic [2:0] CMD_CLEAR_PIXEL = 3'd1;
    localparam logic [2:0] CMD_DRAW_CHAR   = 3'd2;
    localparam logic [2:0] CMD_BRAILLE     = 3'd3;
    localparam logic [2:0] CMD_QUADRANT    = 3'd4;
    localparam logic [2:0] CMD_HALF_BLOCK  = 3'd5;

    // character range handled by the font
    localparam logic [7:0] CHAR_NULL   = 8'd0;
    localparam logic [7:0] CHAR_FIRST  = 8'd32;
    localparam logic [7:0] CHAR_LOWER  = 8'd97;
    localparam logic [7:0] CHAR_LAST   = 8'd127;
    localparam int         FONT_BYTES  = 195;

    // code points
    localparam logic [15:0] GLYPH_NONE    = 16'h0000;
    localparam logic [15:0] GLYPH_BRAILLE = 16'h2800;

    // item class decided at accept time
    typedef enum logic [2:0] {
        OP_NONE,
        OP_PIXEL,
        OP_CHAR,
        OP_READ1,
        OP_READ2
    } op_t;

    // frame memory operation for the current cycle
    typedef enum logic [2:0] {
        MEM_IDLE,
        MEM_CLEAR,
        MEM_READ,
        MEM_PIX_WRITE,
        MEM_FONT_WRITE
    } mem_op_t;

    // controller states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PIX_RD,
        ST_PIX_WR,
        ST_CHR_W0,
        ST_CHR_W1,
        ST_CHR_W2,
        ST_RD_LO,
        ST_RD_HI,
        ST_GLYPH,
        ST_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic       load_item;
        mem_op_t    mem_op;
        logic [1:0] offset;
        logic       cap_lo;
        logic       glyph_load;
        logic       out_load;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        op_t  item_op;
        logic clear_last;
    } dp_stat_t;

    // 3-column font, codes 32..96
    localparam logic [7:0] FONT_ROM [0:FONT_BYTES-1] = '{
        8'd0,   8'd0,   8'd0,   8'd0,   8'd125, 8'd0,   8'd96,  8'd0,   8'd96,
        8'd127, 8'd20,  8'd127, 8'd50,  8'd107, 8'd38,  8'd39,  8'd8,   8'd115,
        8'd62,  8'd107, 8'd42,  8'd0,   8'd96,  8'd0,   8'd28,  8'd34,  8'd65,
        8'd65,  8'd34,  8'd28,  8'd107, 8'd62,  8'd107, 8'd8,   8'd62,  8'd8,
        8'd2,   8'd3,   8'd0,   8'd8,   8'd8,   8'd8,   8'd3,   8'd3,   8'd0,
        8'd3,   8'd28,  8'd96,  8'd62,  8'd65,  8'd62,  8'd33,  8'd127, 8'd1,
        8'd35,  8'd69,  8'd57,  8'd34,  8'd73,  8'd54,  8'd60,  8'd4,   8'd127,
        8'd122, 8'd73,  8'd78,  8'd62,  8'd73,  8'd38,  8'd64,  8'd79,  8'd112,
        8'd54,  8'd73,  8'd54,  8'd50,  8'd73,  8'd62,  8'd0,   8'd20,  8'd0,
        8'd2,   8'd20,  8'd0,   8'd8,   8'd20,  8'd34,  8'd20,  8'd20,  8'd20,
        8'd34,  8'd20,  8'd8,   8'd32,  8'd77,  8'd48,  8'd63,  8'd65,  8'd125,
        8'd127, 8'd80,  8'd127, 8'd127, 8'd73,  8'd54,  8'd62,  8'd65,  8'd34,
        8'd127, 8'd65,  8'd62,  8'd127, 8'd73,  8'd65,  8'd127, 8'd72,  8'd72,
        8'd62,  8'd65,  8'd46,  8'd127, 8'd8,   8'd127, 8'd65,  8'd127, 8'd65,
        8'd2,   8'd1,   8'd126, 8'd127, 8'd8,   8'd119, 8'd127, 8'd1,   8'd1,
        8'd127, 8'd62,  8'd127, 8'd127, 8'd64,  8'd127, 8'd127, 8'd65,  8'd127,
        8'd127, 8'd72,  8'd48,  8'd62,  8'd69,  8'd63,  8'd127, 8'd72,  8'd55,
        8'd50,  8'd73,  8'd38,  8'd64,  8'd127, 8'd64,  8'd127, 8'd1,   8'd127,
        8'd124, 8'd3,   8'd124, 8'd127, 8'd14,  8'd127, 8'd119, 8'd8,   8'd119,
        8'd112, 8'd15,  8'd112, 8'd71,  8'd73,  8'd113, 8'd127, 8'd65,  8'd65,
        8'd96,  8'd28,  8'd3,   8'd65,  8'd65,  8'd127, 8'd32,  8'd64,  8'd32,
        8'd1,   8'd1,   8'd1,   8'd64,  8'd32,  8'd0
    };

    // font byte lookup
    function automatic logic [7:0] font_byte(input logic [7:0] idx);
        logic [7:0] val;
        val = 8'd0;
        if (int'(idx) < FONT_BYTES)
        begin
            val = FONT_ROM[idx];
        end
        return val;
    endfunction

    // 2x2 cell pattern to quadrant code point
    function automatic logic [15:0] quad_glyph(input logic [3:0] pat);
        logic [15:0] cp;
        unique case (pat)
            4'd0:    cp = 16'h0020;
            4'd1:    cp = 16'h2596;
            4'd2:    cp = 16'h2598;
            4'd3:    cp = 16'h258C;
            4'd4:    cp = 16'h2597;
            4'd5:    cp = 16'h2584;
            4'd6:    cp = 16'h259A;
            4'd7:    cp = 16'h2599;
            4'd8:    cp = 16'h259D;
            4'd9:    cp = 16'h259E;
            4'd10:   cp = 16'h2580;
            4'd11:   cp = 16'h259B;
            4'd12:   cp = 16'h2590;
            4'd13:   cp = 16'h259F;
            4'd14:   cp = 16'h259C;
            default: cp = 16'h2588;
        endcase
        return cp;
    endfunction

    // 1x2 cell pattern to half-block code point
    function automatic logic [15:0] half_glyph(input logic [1:0] pat);
        logic [15:0] cp;
        unique case (pat)
            2'd0:    cp = 16'h0020;
            2'd1:    cp = 16'h2584;
            2'd2:    cp = 16'h2580;
            default: cp = 16'h2588;
        endcase
        return cp;
    endfunction

endpackage

// ===== rtl/mono_page_framebuffer_engine.sv =====
// mono_page_framebuffer_engine: top level of the page-organized framebuffer
// depends on mpfb_pkg, mpfb_ctrl, mpfb_dp (which holds mpfb_ram)
//
//   channel  direction  handshake            payload
//   in       to block   in_valid/in_stall    command x_coord y_coord char_code
//                                            char_index last_char
//   out      from block out_valid/out_stall  glyph_code rejected
//
// one item at a time, one result beat per item: rejected, null and stopped
// items go straight to done, pixel writes read and then write back a byte,
// half-block reads fetch one byte, braille and quadrant reads two, and
// character blits write each font column; after reset a clearing pass writes
// zero to all SCREEN_WIDTH*SCREEN_PAGES bytes, in_stall is high meanwhile
// a stalled result holds in the output register; the next item is accepted
// meanwhile and waits done until the output register frees
module mono_page_framebuffer_engine
    import mpfb_pkg::*;
#(
    parameter int SCREEN_WIDTH = 128,
    parameter int SCREEN_PAGES = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  command,
    input  logic [7:0]  x_coord,
    input  logic [6:0]  y_coord,
    input  logic [7:0]  char_code,
    input  logic [4:0]  char_index,
    input  logic        last_char,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] glyph_code,
    output logic        rejected
);

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    // sequencer
    mpfb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_stall (out_stall),
        .stat      (dp_stat),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .cmd       (dp_cmd)
    );

    // decode, frame memory and results
    mpfb_dp #(
        .SCREEN_WIDTH (SCREEN_WIDTH),
        .SCREEN_PAGES (SCREEN_PAGES)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .command    (command),
        .x_coord    (x_coord),
        .y_coord    (y_coord),
        .char_code  (char_code),
        .char_index (char_index),
        .last_char  (last_char),
        .cmd        (dp_cmd),
        .stat       (dp_stat),
        .glyph_code (glyph_code),
        .rejected   (rejected)
    );

`ifndef NO_ASSERTIONS
    // no beat accepted while the clearing pass runs
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (dp_cmd.mem_op == MEM_CLEAR) |-> in_stall)
        else $error("item accepted during clearing pass");

    // one item in work at a time
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("second item accepted while busy");

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.out_load |-> !(out_valid && out_stall))
        else $error("result register overwritten while stalled");

    // rejected beats carry no code point
    a_reject_no_glyph: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && rejected) |-> (glyph_code == GLYPH_NONE))
        else $error("rejected beat with nonzero glyph");
`endif

endmodule

// ===== rtl/mpfb_ram.sv =====
// mpfb_ram: generic single-port RAM with registered read data
// no dependencies
module mpfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    // one access per cycle, read data updates only on reads
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/mpfb_dp.sv =====
// mpfb_dp: item decode, frame memory, glyph assembly and result registers
// depends on mpfb_pkg and mpfb_ram
module mpfb_dp
    import mpfb_pkg::*;
#(
    parameter int SCREEN_WIDTH = 128,
    parameter int SCREEN_PAGES = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic [2:0] command,
    input  logic [7:0] x_coord,
    input  logic [6:0] y_coord,
    input  logic [7:0] char_code,
    input  logic [4:0] char_index,
    input  logic       last_char,
    input  dp_cmd_t    cmd,
    output dp_stat_t   stat,
    output logic [15:0] glyph_code,
    output logic       rejected
);

    localparam int DEPTH = SCREEN_WIDTH * SCREEN_PAGES;
    localparam int AW    = $clog2(DEPTH);
    localparam int ROWS  = SCREEN_PAGES * 8;

    localparam logic [8:0] W_LIM      = 9'(SCREEN_WIDTH);
    localparam logic [8:0] HALF_W_LIM = 9'(SCREEN_WIDTH / 2);
    localparam logic [9:0] W_LIM10    = 10'(SCREEN_WIDTH);
    localparam logic [7:0] ROWS_LIM   = 8'(ROWS);
    localparam logic [7:0] CELL2_LIM  = 8'(SCREEN_PAGES * 2);
    localparam logic [7:0] CELL4_LIM  = 8'(SCREEN_PAGES * 4);
    localparam logic [7:0] PAGE_LIM   = 8'(SCREEN_PAGES);
    localparam logic [7:0] TOP_ROW    = 8'(ROWS - 1);
    localparam logic [6:0] TOP_PAGE   = 7'(SCREEN_PAGES - 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    // decode of the offered item
    op_t        dec_op;
    logic       dec_rej;
    logic [6:0] dec_page;
    logic [8:0] dec_col;
    logic [2:0] dec_shift;
    logic [7:0] dec_base;
    logic       dec_stop;
    logic [AW-1:0] dec_addr;

    logic [7:0] y_ext;
    logic [7:0] y_flip;
    logic [8:0] chr_start;
    logic [9:0] chr_end;
    logic [6:0] glyph_no;
    logic [15:0] addr_wide;

    // item registers
    logic [AW-1:0] addr_reg;
    logic [2:0]    shift_reg;
    logic [7:0]    base_reg;
    logic [2:0]    cmd_reg;
    logic          rej_reg;
    logic [7:0]    lo_reg;
    logic [15:0]   glyph_reg;
    logic [15:0]   glyph_out_reg;
    logic          rej_out_reg;
    logic          stopped_reg;
    logic          stopped_next;
    logic [AW-1:0] clr_cnt_reg;

    // memory port
    logic          ram_en;
    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [7:0]    ram_wdata;
    logic [7:0]    ram_rdata;
    logic [7:0]    pix_mask;
    logic [7:0]    pix_byte;

    // glyph assembly
    logic [7:0]  lo_byte;
    logic [7:0]  sh_lo;
    logic [7:0]  sh_hi;
    logic [7:0]  braille_bits;
    logic [15:0] glyph_next;

    assign y_ext     = {1'b0, y_coord};
    assign y_flip    = TOP_ROW - y_ext;
    assign chr_start = {1'b0, x_coord} + {2'b00, char_index, 2'b00};
    assign chr_end   = {1'b0, chr_start} + 10'd2;
    assign glyph_no  = (char_code >= CHAR_LOWER) ? 7'(char_code - 8'd64)
                                                 : 7'(char_code - CHAR_FIRST);

    // command decode and range checks
    always_comb
    begin
        dec_op    = OP_NONE;
        dec_rej   = 1'b0;
        dec_page  = 7'd0;
        dec_col   = 9'd0;
        dec_shift = 3'd0;
        dec_stop  = stopped_reg;
        dec_base  = {1'b0, glyph_no} + {glyph_no, 1'b0};
        unique case (command)
            CMD_SET_PIXEL, CMD_CLEAR_PIXEL:
            begin
                dec_page  = {3'b000, y_flip[6:3]};
                dec_col   = {1'b0, x_coord};
                dec_shift = y_flip[2:0];
                if ({1'b0, x_coord} < W_LIM && y_ext < ROWS_LIM)
                begin
                    dec_op = OP_PIXEL;
                end
                else
                begin
                    dec_rej = 1'b1;
                end
            end
            CMD_DRAW_CHAR:
            begin
                dec_page = y_coord;
                dec_col  = chr_start;
                if (!stopped_reg)
                begin
                    if (char_code == CHAR_NULL)
                    begin
                        dec_stop = 1'b1;
                    end
                    else if (char_code < CHAR_FIRST || char_code > CHAR_LAST)
                    begin
                        dec_rej = 1'b1;
                    end
                    else if (y_ext >= PAGE_LIM || chr_end >= W_LIM10)
                    begin
                        dec_rej = 1'b1;
                    end
                    else
                    begin
                        dec_op = OP_CHAR;
                    end
                end
                if (last_char)
                begin
                    dec_stop = 1'b0;
                end
            end
            CMD_BRAILLE:
            begin
                dec_page  = TOP_PAGE - {1'b0, y_coord[6:1]};
                dec_col   = {x_coord, 1'b0};
                dec_shift = y_coord[0] ? 3'd0 : 3'd4;
                if ({1'b0, x_coord} < HALF_W_LIM && y_ext < CELL2_LIM)
                begin
                    dec_op = OP_READ2;
                end
                else
                begin
                    dec_rej = 1'b1;
                end
            end
            CMD_QUADRANT:
            begin
                dec_page  = TOP_PAGE - {2'b00, y_coord[6:2]};
                dec_col   = {x_coord, 1'b0};
                dec_shift = {~y_coord[1:0], 1'b0};
                if ({1'b0, x_coord} < HALF_W_LIM && y_ext < CELL4_LIM)
                begin
                    dec_op = OP_READ2;
                end
                else
                begin
                    dec_rej = 1'b1;
                end
            end
            CMD_HALF_BLOCK:
            begin
                dec_page  = TOP_PAGE - {2'b00, y_coord[6:2]};
                dec_col   = {1'b0, x_coord};
                dec_shift = {~y_coord[1:0], 1'b0};
                if ({1'b0, x_coord} < W_LIM && y_ext < CELL4_LIM)
                begin
                    dec_op = OP_READ1;
                end
                else
                begin
                    dec_rej = 1'b1;
                end
            end
            default:
            begin
                dec_rej = 1'b1;
            end
        endcase
    end

    // page times width plus column
    assign addr_wide = 16'(dec_page) * 16'(SCREEN_WIDTH) + 16'(dec_col);
    assign dec_addr  = addr_wide[AW-1:0];

    assign stat.item_op    = dec_op;
    assign stat.clear_last = (clr_cnt_reg == LAST_ADDR);

    assign stopped_next = cmd.load_item && (command == CMD_DRAW_CHAR) ? dec_stop
                                                                      : stopped_reg;

    // control state: string stop flag and clear sweep counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stopped_reg <= 1'b0;
            clr_cnt_reg <= '0;
        end
        else
        begin
            stopped_reg <= stopped_next;
            if (cmd.mem_op == MEM_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
        end
    end

    // pixel read-modify-write data
    assign pix_mask = 8'd1 << shift_reg;
    assign pix_byte = (cmd_reg == CMD_SET_PIXEL) ? (ram_rdata | pix_mask)
                                                 : (ram_rdata & ~pix_mask);

    // frame memory port mux
    always_comb
    begin
        ram_en    = 1'b0;
        ram_we    = 1'b0;
        ram_addr  = addr_reg + AW'(cmd.offset);
        ram_wdata = 8'd0;
        unique case (cmd.mem_op)
            MEM_IDLE:
            begin
                ram_en = 1'b0;
            end
            MEM_CLEAR:
            begin
                ram_en   = 1'b1;
                ram_we   = 1'b1;
                ram_addr = clr_cnt_reg;
            end
            MEM_READ:
            begin
                ram_en = 1'b1;
            end
            MEM_PIX_WRITE:
            begin
                ram_en    = 1'b1;
                ram_we    = 1'b1;
                ram_wdata = pix_byte;
            end
            MEM_FONT_WRITE:
            begin
                ram_en    = 1'b1;
                ram_we    = 1'b1;
                ram_wdata = font_byte(base_reg + 8'(cmd.offset));
            end
            default:
            begin
                ram_en = 1'b0;
            end
        endcase
    end

    mpfb_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_frame_ram (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // glyph from the fetched bytes
    assign lo_byte = (cmd_reg == CMD_HALF_BLOCK) ? ram_rdata : lo_reg;
    assign sh_lo   = lo_byte >> shift_reg;
    assign sh_hi   = ram_rdata >> shift_reg;
    assign braille_bits = {sh_hi[0], sh_lo[0], sh_hi[1], sh_hi[2],
                           sh_hi[3], sh_lo[1], sh_lo[2], sh_lo[3]};

    always_comb
    begin
        unique case (cmd_reg)
            CMD_BRAILLE:    glyph_next = GLYPH_BRAILLE + {8'd0, braille_bits};
            CMD_QUADRANT:   glyph_next = quad_glyph({sh_hi[1:0], sh_lo[1:0]});
            CMD_HALF_BLOCK: glyph_next = half_glyph(sh_lo[1:0]);
            default:        glyph_next = GLYPH_NONE;
        endcase
    end

    // item and result payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            addr_reg  <= dec_addr;
            shift_reg <= dec_shift;
            base_reg  <= dec_base;
            cmd_reg   <= command;
            rej_reg   <= dec_rej;
            glyph_reg <= GLYPH_NONE;
        end
        else if (cmd.glyph_load)
        begin
            glyph_reg <= glyph_next;
        end
        if (cmd.cap_lo)
        begin
            lo_reg <= ram_rdata;
        end
        if (cmd.out_load)
        begin
            glyph_out_reg <= glyph_reg;
            rej_out_reg   <= rej_reg;
        end
    end

    assign glyph_code = glyph_out_reg;
    assign rejected   = rej_out_reg;

endmodule

// ===== rtl/mpfb_ctrl.sv =====
// mpfb_ctrl: sequencer for clear sweep, pixel, character and readout items
// depends on mpfb_pkg
module mpfb_ctrl
    import mpfb_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     out_stall,
    input  dp_stat_t stat,
    output logic     in_stall,
    output logic     out_valid,
    output dp_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;
    op_t    op_reg;
    op_t    op_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;
    logic   accept;

    assign out_free = !out_valid_reg || !out_stall;
    assign accept   = (state_reg == ST_IDLE) && in_valid;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (stat.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (stat.item_op)
                        OP_PIXEL:          state_next = ST_PIX_RD;
                        OP_CHAR:           state_next = ST_CHR_W0;
                        OP_READ1, OP_READ2: state_next = ST_RD_LO;
                        default:           state_next = ST_DONE;
                    endcase
                end
            end
            ST_PIX_RD: state_next = ST_PIX_WR;
            ST_PIX_WR: state_next = ST_DONE;
            ST_CHR_W0: state_next = ST_CHR_W1;
            ST_CHR_W1: state_next = ST_CHR_W2;
            ST_CHR_W2: state_next = ST_DONE;
            ST_RD_LO:  state_next = (op_reg == OP_READ2) ? ST_RD_HI : ST_GLYPH;
            ST_RD_HI:  state_next = ST_GLYPH;
            ST_GLYPH:  state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // datapath commands
    always_comb
    begin
        cmd            = '0;
        cmd.mem_op     = MEM_IDLE;
        cmd.load_item  = accept;
        unique case (state_reg)
            ST_CLEAR:  cmd.mem_op = MEM_CLEAR;
            ST_IDLE:   cmd.mem_op = MEM_IDLE;
            ST_PIX_RD: cmd.mem_op = MEM_READ;
            ST_PIX_WR: cmd.mem_op = MEM_PIX_WRITE;
            ST_CHR_W0: cmd.mem_op = MEM_FONT_WRITE;
            ST_CHR_W1:
            begin
                cmd.mem_op = MEM_FONT_WRITE;
                cmd.offset = 2'd1;
            end
            ST_CHR_W2:
            begin
                cmd.mem_op = MEM_FONT_WRITE;
                cmd.offset = 2'd2;
            end
            ST_RD_LO:  cmd.mem_op = MEM_READ;
            ST_RD_HI:
            begin
                cmd.mem_op = MEM_READ;
                cmd.offset = 2'd1;
                cmd.cap_lo = 1'b1;
            end
            ST_GLYPH:  cmd.glyph_load = 1'b1;
            ST_DONE:   cmd.out_load = out_free;
            default:   cmd.mem_op = MEM_IDLE;
        endcase
    end

    // op latch and output valid
    assign op_next = accept ? stat.item_op : op_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            op_reg        <= OP_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule
